/* rtl/size_class_slab_allocator_top_macros.svh */
// Assertion macros for the size-class slab allocator
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SCSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slab allocator check failed");
`define SCSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slab allocator check failed");
`else
`define SCSA_ASSERT(lbl, prop)
`define SCSA_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* rtl/scsa_pkg.sv */
// Shared types, constants and helper functions of the slab allocator
package scsa_pkg;

  // size classes: 16 << c bytes, c = 0..5
  localparam int NUM_CLASSES  = 6;
  localparam int CLASS_W      = 3;
  localparam int MIN_CLASS_LG = 4;
  localparam int MAX_BLOCK    = 512;

  // default geometry
  localparam int DEF_PAGE_BYTES      = 4096;
  localparam int DEF_PAGES_PER_CLASS = 8;
  localparam int DEF_HEADER_BYTES    = 64;
  localparam int DEF_SLOTS_PER_PAGE  = 64;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] block_address;
  } rsp_t;

  // slots of a class that fit behind the header, capped by the bitmap width
  function automatic int usable_slots(int page_bytes, int header_bytes, int slots, int cls);
    int n;
    n = (page_bytes - header_bytes) >> (MIN_CLASS_LG + cls);
    if (n > slots) n = slots;
    return n;
  endfunction

endpackage

/* rtl/size_class_slab_allocator_top.sv */
// Allocate scans 1..PAGES_PER_CLASS pages of its class, in order, from accept to output beat,
// one bitmap memory read per page; a free decodes, reads and writes back; an oversize request goes to done.
// One request is in flight at a time; the next is accepted the cycle after its result is
// placed in the output register, which may still be waiting on out_stall_i.
// After reset a clearing pass writes all 6*PAGES_PER_CLASS bitmap words to zero, one per
// cycle, with in_stall_o high; pool_base resets to zero and is writable throughout.
`include "size_class_slab_allocator_top_macros.svh"
module size_class_slab_allocator_top #(
  parameter int PAGE_BYTES      = scsa_pkg::DEF_PAGE_BYTES,
  parameter int PAGES_PER_CLASS = scsa_pkg::DEF_PAGES_PER_CLASS,
  parameter int HEADER_BYTES    = scsa_pkg::DEF_HEADER_BYTES,
  parameter int SLOTS_PER_PAGE  = scsa_pkg::DEF_SLOTS_PER_PAGE
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  scsa_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output scsa_pkg::rsp_t out_data_o
);
  import scsa_pkg::*;

  localparam int NUM_PAGES = NUM_CLASSES * PAGES_PER_CLASS;
  localparam int PG_W      = $clog2(NUM_PAGES);
  localparam int SLOT_W    = $clog2(SLOTS_PER_PAGE);
  localparam int PCNT_W    = $clog2(PAGES_PER_CLASS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_FREE_DEC,
    S_FREE_RD,
    S_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [PG_W-1:0]           clr_q, clr_d;
  logic [31:0]               pool_base_q, pool_base_d;
  logic [CLASS_W-1:0]        cls_q, cls_d;
  logic [PG_W-1:0]           pg_q, pg_d;
  logic [PCNT_W-1:0]         p_q, p_d;
  logic [31:0]               page_addr_q, page_addr_d;
  logic [31:0]               off_q, off_d;
  logic [SLOT_W-1:0]         slot_q, slot_d;
  status_e                   res_status_q, res_status_d;
  logic [31:0]               res_addr_q, res_addr_d;
  logic                      out_valid_q, out_valid_d;
  rsp_t                      out_data_q, out_data_d;

  logic [SLOTS_PER_PAGE-1:0] bitmap_mem [NUM_PAGES];
  logic [SLOTS_PER_PAGE-1:0] mem_rdata_q;
  logic                      mem_we;
  logic                      mem_re;
  logic [PG_W-1:0]           mem_waddr;
  logic [PG_W-1:0]           mem_raddr;
  logic [SLOTS_PER_PAGE-1:0] mem_wdata;

  logic [SLOTS_PER_PAGE-1:0] class_mask [NUM_CLASSES];
  logic [CLASS_W-1:0]        alloc_cls;
  logic                      too_large;
  logic [PG_W-1:0]           alloc_pg;
  logic [SLOTS_PER_PAGE-1:0] free_bits;
  logic [SLOTS_PER_PAGE-1:0] low_bit;
  logic [SLOT_W-1:0]         hit_slot;
  logic [SLOTS_PER_PAGE-1:0] free_bit;
  logic                      dec_ok;
  logic [PG_W-1:0]           dec_page;
  logic [SLOT_W-1:0]         dec_slot;

  // usable-slot masks per class
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_mask
    localparam int Usable = usable_slots(PAGE_BYTES, HEADER_BYTES, SLOTS_PER_PAGE, c);
    for (genvar i = 0; i < SLOTS_PER_PAGE; i++) begin : g_bit
      assign class_mask[c][i] = (i < Usable);
    end
  end

  // map the request size to the smallest class that holds it
  always_comb begin
    alloc_cls = '0;
    for (int c = 0; c < NUM_CLASSES - 1; c++) begin
      if (in_data_i.request_size > 16'(1 << (MIN_CLASS_LG + c))) alloc_cls = CLASS_W'(c + 1);
    end
  end
  assign too_large = in_data_i.request_size > 16'(MAX_BLOCK);
  assign alloc_pg  = PG_W'(32'(alloc_cls) * PAGES_PER_CLASS);

  // lowest usable free slot of the page just read
  assign free_bits = ~mem_rdata_q & class_mask[cls_q];
  assign low_bit   = free_bits & (~free_bits + SLOTS_PER_PAGE'(1));
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
      if (low_bit[i]) hit_slot = hit_slot | SLOT_W'(i);
    end
  end
  assign free_bit = SLOTS_PER_PAGE'(1) << slot_q;

  scsa_free_dec #(
    .PAGE_BYTES      (PAGE_BYTES),
    .PAGES_PER_CLASS (PAGES_PER_CLASS),
    .HEADER_BYTES    (HEADER_BYTES),
    .SLOTS_PER_PAGE  (SLOTS_PER_PAGE)
  ) u_free_dec (
    .off_i  (off_q),
    .ok_o   (dec_ok),
    .page_o (dec_page),
    .slot_o (dec_slot)
  );

  // sequencer: decode, read, modify, write back, hand result to the output register
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    pool_base_d  = cfg_we_i ? cfg_wdata_i : pool_base_q;
    cls_d        = cls_q;
    pg_d         = pg_q;
    p_d          = p_q;
    page_addr_d  = page_addr_q;
    off_d        = off_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = pg_q;
    mem_raddr    = pg_q;
    mem_wdata    = mem_rdata_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + PG_W'(1);
        if (clr_q == PG_W'(NUM_PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.operation == OP_FREE) begin
            off_d   = in_data_i.free_address - pool_base_q;
            state_d = S_FREE_DEC;
          end else if (too_large) begin
            res_status_d = ST_TOO_LARGE;
            res_addr_d   = '0;
            state_d      = S_DONE;
          end else begin
            cls_d       = alloc_cls;
            pg_d        = alloc_pg;
            p_d         = '0;
            page_addr_d = pool_base_q + 32'(HEADER_BYTES)
                        + 32'(alloc_cls) * 32'(PAGES_PER_CLASS * PAGE_BYTES);
            mem_re      = 1'b1;
            mem_raddr   = alloc_pg;
            state_d     = S_ALLOC_RD;
          end
        end
      end
      S_ALLOC_RD: begin
        if (|free_bits) begin
          // claim the slot and write the page back
          mem_we       = 1'b1;
          mem_wdata    = mem_rdata_q | low_bit;
          res_status_d = ST_OK;
          res_addr_d   = page_addr_q + (32'(hit_slot) << (MIN_CLASS_LG + 32'(cls_q)));
          state_d      = S_DONE;
        end else if (p_q == PCNT_W'(PAGES_PER_CLASS - 1)) begin
          res_status_d = ST_FULL;
          res_addr_d   = '0;
          state_d      = S_DONE;
        end else begin
          // advance to the next page of the class
          p_d         = p_q + PCNT_W'(1);
          pg_d        = pg_q + PG_W'(1);
          page_addr_d = page_addr_q + 32'(PAGE_BYTES);
          mem_re      = 1'b1;
          mem_raddr   = pg_q + PG_W'(1);
        end
      end
      S_FREE_DEC: begin
        if (dec_ok) begin
          pg_d      = dec_page;
          slot_d    = dec_slot;
          mem_re    = 1'b1;
          mem_raddr = dec_page;
          state_d   = S_FREE_RD;
        end else begin
          res_status_d = ST_BAD_ADDR;
          res_addr_d   = '0;
          state_d      = S_DONE;
        end
      end
      S_FREE_RD: begin
        res_addr_d = '0;
        if (|(mem_rdata_q & free_bit)) begin
          mem_we       = 1'b1;
          mem_wdata    = mem_rdata_q & ~free_bit;
          res_status_d = ST_OK;
        end else begin
          res_status_d = ST_BAD_ADDR;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_data_d.status        = res_status_q;
          out_data_d.block_address = res_addr_q;
          state_d                  = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // hold state, config and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      pool_base_q  <= '0;
      cls_q        <= '0;
      pg_q         <= '0;
      p_q          <= '0;
      page_addr_q  <= '0;
      off_q        <= '0;
      slot_q       <= '0;
      res_status_q <= ST_OK;
      res_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      pool_base_q  <= pool_base_d;
      cls_q        <= cls_d;
      pg_q         <= pg_d;
      p_q          <= p_d;
      page_addr_q  <= page_addr_d;
      off_q        <= off_d;
      slot_q       <= slot_d;
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
    end
  end

  // bitmap memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) bitmap_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= bitmap_mem[mem_raddr];
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a new output beat only comes out of the result hand-off
  `SCSA_ASSERT_IMPL(a_beat_from_done, $rose(out_valid_o), $past(state_q == S_DONE))
  // an allocate sets exactly one bit, and only a usable one
  `SCSA_ASSERT_IMPL(a_alloc_one_bit, mem_we && state_q == S_ALLOC_RD,
    $countones(mem_wdata ^ mem_rdata_q) == 1
    && ((mem_wdata & ~mem_rdata_q) & ~class_mask[cls_q]) == '0)
  // a free clears exactly one bit that was set
  `SCSA_ASSERT_IMPL(a_free_one_bit, mem_we && state_q == S_FREE_RD,
    $countones(mem_wdata ^ mem_rdata_q) == 1 && (mem_wdata & ~mem_rdata_q) == '0)
  // the page scan stays inside the class
  `SCSA_ASSERT_IMPL(a_scan_in_class, state_q == S_ALLOC_RD,
    pg_q == PG_W'(32'(cls_q) * PAGES_PER_CLASS) + PG_W'(p_q))

endmodule

/* rtl/scsa_free_dec.sv */
// Address decoder of a free: pool offset to page and slot, with range checks
module scsa_free_dec #(
  parameter int PAGE_BYTES      = scsa_pkg::DEF_PAGE_BYTES,
  parameter int PAGES_PER_CLASS = scsa_pkg::DEF_PAGES_PER_CLASS,
  parameter int HEADER_BYTES    = scsa_pkg::DEF_HEADER_BYTES,
  parameter int SLOTS_PER_PAGE  = scsa_pkg::DEF_SLOTS_PER_PAGE,
  localparam int NUM_PAGES      = scsa_pkg::NUM_CLASSES * PAGES_PER_CLASS,
  localparam int PG_W           = $clog2(NUM_PAGES),
  localparam int SLOT_W         = $clog2(SLOTS_PER_PAGE)
) (
  input  logic [31:0]       off_i,
  output logic              ok_o,
  output logic [PG_W-1:0]   page_o,
  output logic [SLOT_W-1:0] slot_o
);
  import scsa_pkg::*;

  localparam int          PL         = $clog2(PAGE_BYTES);
  localparam logic [31:0] POOL_BYTES = 32'(NUM_PAGES * PAGE_BYTES);

  logic [31:0]        pg_full;
  logic [PL-1:0]      inpage;
  logic [PL-1:0]      rel;
  logic [PL-1:0]      slot_full;
  logic [CLASS_W-1:0] cls;
  logic               in_pool;
  logic               hdr_ok;
  logic               aligned;
  logic               in_range;

  // split the offset into page and in-page position
  assign in_pool = off_i < POOL_BYTES;
  assign pg_full = off_i >> PL;
  assign inpage  = off_i[PL-1:0];
  assign hdr_ok  = inpage >= PL'(HEADER_BYTES);
  assign rel     = inpage - PL'(HEADER_BYTES);

  // pick the class that owns the page, then check slot alignment and range
  always_comb begin
    cls       = '0;
    aligned   = 1'b0;
    in_range  = 1'b0;
    slot_full = '0;
    for (int c = 1; c < NUM_CLASSES; c++) begin
      if (pg_full >= 32'(c * PAGES_PER_CLASS)) cls = CLASS_W'(c);
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls == CLASS_W'(c)) begin
        aligned   = (rel & PL'((1 << (MIN_CLASS_LG + c)) - 1)) == '0;
        slot_full = rel >> (MIN_CLASS_LG + c);
        in_range  = slot_full <
                    PL'(usable_slots(PAGE_BYTES, HEADER_BYTES, SLOTS_PER_PAGE, c));
      end
    end
  end

  assign ok_o   = in_pool && hdr_ok && aligned && in_range;
  assign page_o = PG_W'(pg_full);
  assign slot_o = SLOT_W'(slot_full);

endmodule
